### rtl/core/double_ended_queue_core_defines.svh
// Assertion macros used by the queue checker.
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue check failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

### rtl/core/deq_pkg.sv
// Types and constants shared by the double-ended queue modules.
package deq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ST_W   = 2;
  // op and value packed, padded to whole bytes
  localparam int unsigned IN_W   = ((OP_W + WORD_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;   // apply the accepted item to indices, count and store
    logic read;   // fetch front and back words
    logic load;   // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free; // output register can take a new result this cycle
  } sts_t;

endpackage

### rtl/core/deq_ctrl.sv
// Sequencer for the double-ended queue: take, read, load.
module deq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  deq_pkg::sts_t sts,
  output deq_pkg::cmd_t cmd
);

  deq_pkg::state_t state_r;
  deq_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      deq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = deq_pkg::S_READ;
        end
      end
      deq_pkg::S_READ: begin
        state_nxt = deq_pkg::S_LOAD;
      end
      deq_pkg::S_LOAD: begin
        if (sts.out_free) begin
          state_nxt = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = deq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      deq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      deq_pkg::S_READ: begin
        cmd.read = 1'b1;
      end
      deq_pkg::S_LOAD: begin
        cmd.load = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/deq_dp.sv
// Ring store, indices, count and output register of the double-ended queue.
module deq_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  deq_pkg::cmd_t                    cmd,
  output deq_pkg::sts_t                    sts,
  input  deq_pkg::op_t                     in_op,
  input  logic signed [deq_pkg::WORD_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output deq_pkg::status_t                 out_status,
  output logic signed [deq_pkg::WORD_W-1:0] out_front,
  output logic signed [deq_pkg::WORD_W-1:0] out_back,
  output logic [$clog2(DEPTH+1)-1:0]       out_occupancy,
  output logic                             out_is_empty
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  logic [deq_pkg::WORD_W-1:0] mem [DEPTH];

  logic [IW-1:0]              front_r, front_nxt;
  logic [IW-1:0]              back_r, back_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  deq_pkg::status_t           status_r, status_nxt;
  logic [deq_pkg::WORD_W-1:0] rd_front_r, rd_back_r;
  logic                       out_valid_r;
  deq_pkg::status_t           out_status_r;
  logic [deq_pkg::WORD_W-1:0] out_front_r, out_back_r;
  logic [CW-1:0]              out_count_r;
  logic                       out_empty_r;

  logic          full, empty, wr_en;
  logic [IW-1:0] wr_addr, front_prev, front_next, back_prev, back_next;

  always_comb begin
    front_prev = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
    front_next = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
    back_prev  = (back_r == '0) ? LAST_IDX : back_r - 1'b1;
    back_next  = (back_r == LAST_IDX) ? '0 : back_r + 1'b1;
  end

  always_comb begin
    full       = (count_r == CW'(DEPTH));
    empty      = (count_r == '0);
    wr_en      = 1'b0;
    wr_addr    = back_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (cmd.take) begin
      status_nxt = deq_pkg::ST_OK;
      case (in_op)
        deq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = deq_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = back_r;
            back_nxt  = back_next;
            count_nxt = count_r + 1'b1;
          end
        end
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = deq_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = front_prev;
            front_nxt = front_prev;
            count_nxt = count_r + 1'b1;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_nxt = deq_pkg::ST_EMPTY;
          end else begin
            front_nxt = front_next;
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
          if (empty) begin
            status_nxt = deq_pkg::ST_EMPTY;
          end else begin
            back_nxt  = back_prev;
            count_nxt = count_r - 1'b1;
          end
        end
      endcase
    end
  end

  // ring store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_front_r <= mem[front_r];
      rd_back_r  <= mem[back_prev];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  // output register: hold while stalled, drop valid once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= status_r;
      out_front_r  <= empty ? '1 : rd_front_r;
      out_back_r   <= empty ? '1 : rd_back_r;
      out_count_r  <= count_r;
      out_empty_r  <= empty;
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_front      = out_front_r;
  assign out_back       = out_back_r;
  assign out_occupancy  = out_count_r;
  assign out_is_empty   = out_empty_r;

endmodule

### rtl/core/double_ended_queue_core.sv
// A taken item passes through the read state, then the load state, into the output register;
// it waits in the load state while the output is stalled. Items are taken one at a time: the
// ring store's registered read fetches front and back words after the update, before the load.
// An input transfer is taken while an earlier result still waits at the output.
// Reset (rst_n low, synchronous) empties the queue and clears the output valid;
// store contents are left as they are and are never used before being written.
module double_ended_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // fields from bit 0 up: op[1:0], value[33:2], zero padding
  input  logic [deq_pkg::IN_W-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // fields from bit 0 up: status, front_value, back_value, occupancy, is_empty,
  // zero padding
  output logic [((2 * deq_pkg::WORD_W + deq_pkg::ST_W + $clog2(DEPTH+1) + 1 + 7) / 8) * 8 - 1:0]
                               out_tdata
);

  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned FLD_W  = 2 * deq_pkg::WORD_W + deq_pkg::ST_W + CW + 1;
  localparam int unsigned OUT_W  = ((FLD_W + 7) / 8) * 8;
  localparam int unsigned PAD_W  = OUT_W - FLD_W;

  deq_pkg::cmd_t cmd;
  deq_pkg::sts_t sts;

  deq_pkg::op_t                      in_op;
  logic signed [deq_pkg::WORD_W-1:0] in_value;
  deq_pkg::status_t                  out_status;
  logic signed [deq_pkg::WORD_W-1:0] out_front, out_back;
  logic [CW-1:0]                     out_occupancy;
  logic                              out_is_empty;

  // unpack the input transfer; padding bits are ignored
  assign in_op    = deq_pkg::op_t'(in_tdata[deq_pkg::OP_W-1:0]);
  assign in_value = in_tdata[deq_pkg::OP_W +: deq_pkg::WORD_W];

  // the controller sequences take, read and load; the datapath owns the queue state
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_op         (in_op),
    .in_value      (in_value),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_status    (out_status),
    .out_front     (out_front),
    .out_back      (out_back),
    .out_occupancy (out_occupancy),
    .out_is_empty  (out_is_empty)
  );

  // pack the result, lowest field first, zero-fill to whole bytes
  generate
    if (PAD_W > 0) begin : g_pad
      assign out_tdata = {{PAD_W{1'b0}}, out_is_empty, out_occupancy, out_back, out_front,
                          out_status};
    end else begin : g_nopad
      assign out_tdata = {out_is_empty, out_occupancy, out_back, out_front, out_status};
    end
  endgenerate

endmodule

### rtl/core/deq_chk.sv
// Port-level checker for the double-ended queue, bound to the top level.
`include "double_ended_queue_core_defines.svh"

module deq_chk #(
  parameter int unsigned DEPTH = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [((2 * deq_pkg::WORD_W + deq_pkg::ST_W + $clog2(DEPTH+1) + 1 + 7) / 8) * 8 - 1:0]
                              out_tdata
);

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned FR_LO = deq_pkg::ST_W;
  localparam int unsigned BK_LO = FR_LO + deq_pkg::WORD_W;
  localparam int unsigned OC_LO = BK_LO + deq_pkg::WORD_W;
  localparam int unsigned EM_B  = OC_LO + CW;

  logic [deq_pkg::ST_W-1:0]   st;
  logic [deq_pkg::WORD_W-1:0] fr, bk;
  logic [CW-1:0]              oc;
  logic                       em;

  assign st = out_tdata[deq_pkg::ST_W-1:0];
  assign fr = out_tdata[FR_LO +: deq_pkg::WORD_W];
  assign bk = out_tdata[BK_LO +: deq_pkg::WORD_W];
  assign oc = out_tdata[OC_LO +: CW];
  assign em = out_tdata[EM_B];

  // a stalled result holds
  `DEQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // empty flag agrees with the count
  `DEQ_ASSERT_NOW(a_empty_flag, out_tvalid, em == (oc == '0))
  // an empty queue shows all ones at both ends
  `DEQ_ASSERT_NOW(a_empty_words, out_tvalid && em, (fr == '1) && (bk == '1))
  // a dropped push only happens at full occupancy
  `DEQ_ASSERT_NOW(a_full_drop, out_tvalid && (st == deq_pkg::ST_FULL), oc == CW'(DEPTH))
  // one item in flight: no transfer straight after a transfer
  `DEQ_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)

endmodule

bind double_ended_queue_core deq_chk #(
  .DEPTH (DEPTH)
) u_deq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### test/tb_double_ended_queue_core.sv
// Testbench for the double-ended queue core: stream stimulus, local queue predictor, result checks.
`timescale 1ns / 100ps

module tb_double_ended_queue_core;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned FILL_W     = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W     = deq_pkg::WORD_W;
  localparam int unsigned ST_W       = deq_pkg::ST_W;
  localparam int unsigned IN_W       = deq_pkg::IN_W;
  localparam int unsigned OUT_W      = ((2 * WORD_W + ST_W + FILL_W + 1 + 7) / 8) * 8;
  localparam int unsigned STALL_LEN  = 150;   // long receiver hold-off under pressure
  localparam int unsigned IDLE_LIMIT = 2000;  // cycles without any transfer
  localparam int unsigned SETTLE     = 8;     // margin after the last result

  // One result as the block reports it.
  typedef struct {
    deq_pkg::status_t  status;
    logic [WORD_W-1:0] front_word;
    logic [WORD_W-1:0] back_word;
    logic [FILL_W-1:0] fill;
    logic              empty;
  } deq_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;  // op[1:0], value[33:2], zero padding
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;     // status, front, back, occupancy, is_empty, padding

  // Local copy of the queue, advanced at each input transfer.
  logic [WORD_W-1:0] ring_words [DEPTH];
  logic [IDX_W-1:0]  head_ptr;
  logic [IDX_W-1:0]  tail_ptr;   // one past the back word
  int unsigned       fill_count;

  deq_view_t   pending_views [$];
  int unsigned error_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned full_drops     = 0;
  int unsigned empty_pops     = 0;
  int unsigned feed_stalls    = 0;
  int unsigned idle_cycles    = 0;
  bit          feed_gaps      = 1'b0;
  bit          drain_gaps     = 1'b0;
  bit          stall_request  = 1'b0;

  double_ended_queue_core #(.DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Apply one operation to the local queue and return the view after it.
  function automatic deq_view_t deque_step(input deq_pkg::op_t op,
                                           input logic [WORD_W-1:0] word);
    deq_view_t view;
    view.status = deq_pkg::ST_OK;
    case (op) inside
      deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
        if (fill_count >= DEPTH) begin
          view.status = deq_pkg::ST_FULL;
        end else if (op == deq_pkg::OP_PUSH_BACK) begin
          ring_words[tail_ptr] = word;
          tail_ptr = tail_ptr + 1'b1;
          fill_count++;
        end else begin
          head_ptr = head_ptr - 1'b1;
          ring_words[head_ptr] = word;
          fill_count++;
        end
      end
      default: begin
        if (fill_count == 0) begin
          view.status = deq_pkg::ST_EMPTY;
        end else if (op == deq_pkg::OP_POP_FRONT) begin
          head_ptr = head_ptr + 1'b1;
          fill_count--;
        end else begin
          tail_ptr = tail_ptr - 1'b1;
          fill_count--;
        end
      end
    endcase
    // Empty queue shows all ones on both ends.
    view.front_word = (fill_count != 0) ? ring_words[head_ptr] : '1;
    view.back_word  = (fill_count != 0) ? ring_words[tail_ptr - 1'b1] : '1;
    view.fill       = FILL_W'(fill_count);
    view.empty      = (fill_count == 0);
    return view;
  endfunction

  // Mix extremes, the empty marker and small values into random words.
  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      4:       return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Offer one item, after a random gap if feed gaps are on, hold it until the transfer, then predict.
  task automatic send_item(input deq_pkg::op_t op, input logic [WORD_W-1:0] word);
    int unsigned gap;
    gap = feed_gaps ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({word, op});
    @(posedge clk);
    while (in_tready !== 1'b1) begin
      feed_stalls++;
      @(posedge clk);
    end
    pending_views.push_back(deque_step(op, word));
    if (pending_views[$].status == deq_pkg::ST_FULL) full_drops++;
    if (pending_views[$].status == deq_pkg::ST_EMPTY) empty_pops++;
    items_sent++;
  endtask

  // Drop the input valid once a group of items is through.
  task automatic release_feed();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Pops on an empty queue, then extremes in and out at both ends.
  task automatic test_empty_queue();
    feed_gaps  = 1'b0;
    drain_gaps = 1'b0;
    send_item(deq_pkg::OP_POP_FRONT, 32'h0000_0000);
    send_item(deq_pkg::OP_POP_BACK, 32'hFFFF_FFFF);
    send_item(deq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_item(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    send_item(deq_pkg::OP_POP_FRONT, 32'h1234_5678);
    send_item(deq_pkg::OP_POP_BACK, 32'h0000_0000);
    release_feed();
  endtask

  // Fill from both ends so the front index wraps below zero, then push on a full queue.
  task automatic test_full_queue();
    int unsigned k;
    feed_gaps  = 1'b1;
    drain_gaps = 1'b1;
    for (k = 0; k < DEPTH; k++) begin
      case (k % 4)
        0:       send_item(deq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
        1:       send_item(deq_pkg::OP_PUSH_BACK, 32'h8000_0000 + k);
        2:       send_item(deq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFF0 + k);
        default: send_item(deq_pkg::OP_PUSH_BACK, 32'h0000_0000);
      endcase
    end
    send_item(deq_pkg::OP_PUSH_BACK, 32'hA5A5_A5A5);
    send_item(deq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A);
    release_feed();
  endtask

  // Runs biased towards pushing or popping swing the queue between empty and full.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned  done;
    int unsigned  run;
    int unsigned  push_pct;
    int unsigned  k;
    deq_pkg::op_t op;
    done = 0;
    while (done < n_items) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 20;
        1:       push_pct = 50;
        default: push_pct = 80;
      endcase
      run        = $urandom_range(16, 64);
      feed_gaps  = ($urandom_range(0, 3) != 0);
      drain_gaps = ($urandom_range(0, 3) != 0);
      for (k = 0; k < run && done < n_items; k++) begin
        if ($urandom_range(0, 99) < push_pct)
          op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
        else
          op = $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
        send_item(op, random_word());
        done++;
      end
    end
    release_feed();
  endtask

  // Hold the receiver off for a long stretch while items keep coming at full rate.
  task automatic test_backpressure(input int unsigned n_items);
    int unsigned  k;
    deq_pkg::op_t op;
    feed_gaps     = 1'b0;
    drain_gaps    = 1'b0;
    stall_request = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 3) != 0)
        op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
      else
        op = $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
      send_item(op, random_word());
    end
    release_feed();
  endtask

  // Receiver: wait a random number of cycles per result, or the long stretch on request.
  initial begin
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_request) begin
        hold = STALL_LEN;
        stall_request = 1'b0;
      end else begin
        hold = drain_gaps ? $urandom_range(0, 4) : 0;
      end
      if (hold != 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin : result_check
    deq_view_t got;
    deq_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status     = deq_pkg::status_t'(out_tdata[ST_W-1:0]);
      got.front_word = out_tdata[ST_W +: WORD_W];
      got.back_word  = out_tdata[ST_W + WORD_W +: WORD_W];
      got.fill       = out_tdata[ST_W + 2 * WORD_W +: FILL_W];
      got.empty      = out_tdata[ST_W + 2 * WORD_W + FILL_W];
      results_seen++;
      if (pending_views.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_views.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    results_seen, got.status, want.status));
        if (got.front_word !== want.front_word)
          report_mismatch($sformatf("result %0d front %h, expected %h",
                                    results_seen, got.front_word, want.front_word));
        if (got.back_word !== want.back_word)
          report_mismatch($sformatf("result %0d back %h, expected %h",
                                    results_seen, got.back_word, want.back_word));
        if (got.fill !== want.fill)
          report_mismatch($sformatf("result %0d occupancy %0d, expected %0d",
                                    results_seen, got.fill, want.fill));
        if (got.empty !== want.empty)
          report_mismatch($sformatf("result %0d is_empty %b, expected %b",
                                    results_seen, got.empty, want.empty));
      end
    end
  end

  // Watchdog: end the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_views.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    head_ptr   = '0;
    tail_ptr   = '0;
    fill_count = 0;
    // Hold reset low, then release it away from the sampling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_full_queue();
    test_random_traffic(1900);
    test_backpressure(40);
    test_random_traffic(60);

    // Drain every outstanding result, then let the pipeline settle.
    while (pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d operations at both ends: %0d pushes dropped when full, %0d pops on empty",
             items_sent, full_drops, empty_pops);
    $display("Input waited %0d cycles for the block to take an item; %0d results checked",
             feed_stalls, results_seen);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### double_ended_queue_core.f
+incdir+rtl/core
rtl/core/deq_pkg.sv
rtl/core/deq_ctrl.sv
rtl/core/deq_dp.sv
rtl/core/double_ended_queue_core.sv
rtl/core/deq_chk.sv
test/tb_double_ended_queue_core.sv
